[design/tlbpt_pkg.sv]
// Shared types and constants for the TLB page table translator.
`default_nettype none

package tlbpt_pkg;

	localparam int ADDR_W     = 16;
	localparam int PAGE_W     = 8;
	localparam int OFFSET_W   = 8;
	localparam int FRAME_W    = 8;
	localparam int FREE_W     = 9;
	localparam int COUNT_W    = 24;
	localparam int PAGE_COUNT = 256;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef logic [PAGE_W-1:0]   page_t;
	typedef logic [FRAME_W-1:0]  frame_t;
	typedef logic [OFFSET_W-1:0] offset_t;
	typedef logic [COUNT_W-1:0]  count_t;

	typedef struct packed {
		logic   valid;
		page_t  page;
		frame_t frame;
	} tlb_entry_t;

	typedef struct packed {
		logic   hit;
		frame_t frame;
	} tlb_link_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_TABLE
	} state_t;

endpackage

`default_nettype wire

[design/tlb_page_table_translator.sv]
// Top level of the TLB page table translator.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_stall   virtual_address
//   output    out        out_valid / out_stall physical_address, tlb_hit, page_fault,
//                                              hit_count, fault_count, access_count
//
// One address at a time: a TLB hit goes through accept and the parallel compare over the
// cell chain; a miss adds a state for the registered page table RAM read.
// Reset clears TLB and page table valid bits at once; no clearing pass is needed.
// A finished result waits in the output register; a stalled output holds the
// block before it completes the next transfer.
`default_nettype none

module tlb_page_table_translator #(
	parameter int TLB_ENTRIES = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [15:0]             virtual_address,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [15:0]                  physical_address,
	output logic                         tlb_hit,
	output logic                         page_fault,
	output logic [23:0]                  hit_count,
	output logic [23:0]                  fault_count,
	output logic [23:0]                  access_count
);

	import tlbpt_pkg::*;

	state_t state_q, state_d;

	page_t   page_q;
	offset_t offset_q;

	logic [PAGE_COUNT-1:0] tv_q;
	logic [FREE_W-1:0]     free_q;
	count_t                hits_q, faults_q, accesses_q;

	logic                  out_valid_q;
	logic [ADDR_W-1:0]     phys_q;
	logic                  hit_q, fault_q;

	logic       out_free;
	logic       finish;
	logic       miss_done;
	logic       accept;
	tlb_link_t  chain_link [TLB_ENTRIES+1];
	tlb_entry_t chain_entry [TLB_ENTRIES];
	tlb_entry_t new_entry;
	frame_t     ram_rdata;
	logic       tbl_valid;
	frame_t     fin_frame;
	logic       fin_fault;

	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	assign tbl_valid = tv_q[page_q];

	assign chain_link[0] = '0;

	assign new_entry.valid = 1'b1;
	assign new_entry.page  = page_q;
	assign new_entry.frame = fin_frame;

	for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
		tlbpt_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.shift_en    (miss_done),
			.entry_in    ((i == 0) ? new_entry : chain_entry[(i == 0) ? 0 : i-1]),
			.lookup_page (page_q),
			.link_in     (chain_link[i]),
			.entry_out   (chain_entry[i]),
			.link_out    (chain_link[i+1])
		);
	end

	tlbpt_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (PAGE_COUNT)
	) u_table (
		.clk   (clk),
		.we    (miss_done && fin_fault),
		.waddr (page_q),
		.wdata (fin_frame),
		.raddr (page_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (!chain_link[TLB_ENTRIES].hit) begin
					state_d = ST_TABLE;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_TABLE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		finish    = 1'b0;
		miss_done = 1'b0;
		fin_fault = 1'b0;
		fin_frame = chain_link[TLB_ENTRIES].frame;
		unique case (state_q)
			ST_IDLE: begin
				finish = 1'b0;
			end
			ST_LOOK: begin
				finish = chain_link[TLB_ENTRIES].hit && out_free;
			end
			ST_TABLE: begin
				finish    = out_free;
				miss_done = out_free;
				fin_fault = !tbl_valid;
				fin_frame = tbl_valid ? ram_rdata : free_q[FRAME_W-1:0];
			end
			default: finish = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			tv_q        <= '0;
			free_q      <= '0;
			hits_q      <= '0;
			faults_q    <= '0;
			accesses_q  <= '0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				out_valid_q <= 1'b1;
				if (accesses_q != COUNT_MAX) begin
					accesses_q <= accesses_q + 1'b1;
				end
				if (!miss_done && hits_q != COUNT_MAX) begin
					hits_q <= hits_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (miss_done && fin_fault) begin
				tv_q[page_q] <= 1'b1;
				free_q       <= free_q + 1'b1;
				if (faults_q != COUNT_MAX) begin
					faults_q <= faults_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q   <= virtual_address[ADDR_W-1:OFFSET_W];
			offset_q <= virtual_address[OFFSET_W-1:0];
		end
		if (finish) begin
			phys_q  <= {fin_frame, offset_q};
			hit_q   <= !miss_done;
			fault_q <= fin_fault;
		end
	end

	assign out_valid        = out_valid_q;
	assign physical_address = phys_q;
	assign tlb_hit          = hit_q;
	assign page_fault       = fault_q;
	assign hit_count        = hits_q;
	assign fault_count      = faults_q;
	assign access_count     = accesses_q;

endmodule

`default_nettype wire

[design/tlbpt_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none

module tlbpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[design/tlbpt_cell.sv]
// One TLB entry cell: holds an entry, compares it, shifts it to its neighbor.
`default_nettype none

module tlbpt_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  shift_en,
	input  wire tlbpt_pkg::tlb_entry_t entry_in,
	input  wire tlbpt_pkg::page_t      lookup_page,
	input  wire tlbpt_pkg::tlb_link_t  link_in,
	output tlbpt_pkg::tlb_entry_t      entry_out,
	output tlbpt_pkg::tlb_link_t       link_out
);

	import tlbpt_pkg::*;

	logic   valid_q;
	page_t  page_q;
	frame_t frame_q;
	logic   match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= entry_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			page_q  <= entry_in.page;
			frame_q <= entry_in.frame;
		end
	end

	assign match = valid_q && (page_q == lookup_page);

	always_comb begin
		entry_out.valid = valid_q;
		entry_out.page  = page_q;
		entry_out.frame = frame_q;
		if (link_in.hit) begin
			link_out = link_in;
		end else begin
			link_out.hit   = match;
			link_out.frame = frame_q;
		end
	end

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the TLB page table translator: driver, monitor and predictor.
module tb_top;
	import tlbpt_pkg::*;

	localparam int TLB_SLOTS = 16;
	localparam int RANDOM_PER_PHASE = 160;
	localparam int DRAIN_CYCLES = 10;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [ADDR_W-1:0] physical_address;
		logic              tlb_hit;
		logic              page_fault;
		count_t            hit_count;
		count_t            fault_count;
		count_t            access_count;
	} translation_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [ADDR_W-1:0] virtual_address = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ADDR_W-1:0] physical_address;
	logic              tlb_hit;
	logic              page_fault;
	count_t            hit_count;
	count_t            fault_count;
	count_t            access_count;

	logic [ADDR_W-1:0] pending_addresses[$];
	translation_t      expected_translations[$];
	translation_t      oldest;

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          mismatches = 0;
	int          translations_checked = 0;
	int          hits_seen = 0;
	int          faults_seen = 0;
	int unsigned cycles = 0;

	logic   tlb_valid [TLB_SLOTS];
	page_t  tlb_page [TLB_SLOTS];
	frame_t tlb_frame [TLB_SLOTS];
	logic   table_valid [PAGE_COUNT];
	frame_t table_frame [PAGE_COUNT];

	logic [FREE_W-1:0]            free_frame;
	logic [$clog2(TLB_SLOTS)-1:0] victim_slot;
	count_t                       hits_total;
	count_t                       faults_total;
	count_t                       accesses_total;

	tlb_page_table_translator #(.TLB_ENTRIES(TLB_SLOTS)) DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic count_t bump(input count_t c);
		return (c == COUNT_MAX) ? c : c + 1'b1;
	endfunction

	task automatic translate_address(input logic [ADDR_W-1:0] va);
		page_t        page;
		offset_t      offset;
		frame_t       frame;
		logic         found;
		logic         fault;
		translation_t t;
		page = va[ADDR_W-1 -: PAGE_W];
		offset = va[OFFSET_W-1:0];
		frame = '0;
		found = 1'b0;
		fault = 1'b0;
		accesses_total = bump(accesses_total);
		for (int i = 0; i < TLB_SLOTS; i++) begin
			if (!found && tlb_valid[i] && tlb_page[i] == page) begin
				found = 1'b1;
				frame = tlb_frame[i];
			end
		end
		if (found) begin
			hits_total = bump(hits_total);
		end else begin
			if (table_valid[page]) begin
				frame = table_frame[page];
			end else begin
				fault = 1'b1;
				frame = free_frame[FRAME_W-1:0];
				free_frame = free_frame + 1'b1;
				table_valid[page] = 1'b1;
				table_frame[page] = frame;
				faults_total = bump(faults_total);
			end
			tlb_valid[victim_slot] = 1'b1;
			tlb_page[victim_slot] = page;
			tlb_frame[victim_slot] = frame;
			victim_slot = victim_slot + 1'b1;
		end
		t.physical_address = {frame, offset};
		t.tlb_hit = found;
		t.page_fault = fault;
		t.hit_count = hits_total;
		t.fault_count = faults_total;
		t.access_count = accesses_total;
		expected_translations.push_back(t);
	endtask

	task automatic queue_random_addresses(input int n);
		page_t             hot_base;
		logic [ADDR_W-1:0] va;
		hot_base = page_t'($urandom_range(255));
		repeat (n) begin
			va = ADDR_W'($urandom);
			if ($urandom_range(99) < 60)
				va[ADDR_W-1 -: PAGE_W] = page_t'(hot_base + $urandom_range(19));
			pending_addresses.push_back(va);
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			virtual_address <= '0;
		end else begin
			if (in_valid && !in_stall)
				translate_address(virtual_address);
			if (!in_valid || !in_stall) begin
				if (pending_addresses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					virtual_address <= pending_addresses.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_translations.size() == 0) begin
					$display("%0t: transfer with nothing expected, actual physical_address %h",
						$time, physical_address);
					mismatches++;
				end else begin
					oldest = expected_translations.pop_front();
					check_field("physical_address", 32'(oldest.physical_address),
						32'(physical_address));
					check_field("tlb_hit", 32'(oldest.tlb_hit), 32'(tlb_hit));
					check_field("page_fault", 32'(oldest.page_fault), 32'(page_fault));
					check_field("hit_count", 32'(oldest.hit_count), 32'(hit_count));
					check_field("fault_count", 32'(oldest.fault_count), 32'(fault_count));
					check_field("access_count", 32'(oldest.access_count),
						32'(access_count));
					translations_checked++;
					hits_seen += int'(oldest.tlb_hit);
					faults_seen += int'(oldest.page_fault);
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
				expected_translations.size());
			$display("** tlb_page_table_translator: FAILED **");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < TLB_SLOTS; i++) begin
			tlb_valid[i] = 1'b0;
			tlb_page[i] = '0;
			tlb_frame[i] = '0;
		end
		for (int i = 0; i < PAGE_COUNT; i++) begin
			table_valid[i] = 1'b0;
			table_frame[i] = '0;
		end
		free_frame = '0;
		victim_slot = '0;
		hits_total = '0;
		faults_total = '0;
		accesses_total = '0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// fault, hit, offset extremes, then evict pages 0x00 and 0xff and revisit them
		pending_addresses.push_back(16'h0000);
		pending_addresses.push_back(16'h0000);
		pending_addresses.push_back(16'h00ff);
		pending_addresses.push_back(16'hffff);
		pending_addresses.push_back(16'hff00);
		for (int p = 1; p < 16; p++)
			pending_addresses.push_back({page_t'(p), offset_t'($urandom)});
		pending_addresses.push_back(16'h0012);
		pending_addresses.push_back(16'hffaa);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 73;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 73;
				end
				default: begin
					send_idle_pct = 26;
					stall_pct = 26;
				end
			endcase
			queue_random_addresses(RANDOM_PER_PHASE);
			while (pending_addresses.size() != 0 || in_valid || expected_translations.size() != 0)
				@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d translations under four idle/stall mixes: %0d TLB hits, %0d faults.",
			translations_checked, hits_seen, faults_seen);
		if (mismatches == 0 && expected_translations.size() == 0) begin
			$display("** tlb_page_table_translator: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				expected_translations.size());
			$display("** tlb_page_table_translator: FAILED **");
		end
		$finish;
	end

endmodule

[sim.f]
design/tlbpt_pkg.sv
design/tlbpt_ram.sv
design/tlbpt_cell.sv
design/tlb_page_table_translator.sv
test/tb_top.sv
